[hw/rtl/nec_ir_pkg.sv]
// Package for the NEC infrared frame decoder: request kinds, timing windows
// in microseconds, and the decoder status record.
// Depends on nothing; imported by nec_ir_frame_decoder.
package nec_ir_pkg;

  localparam int unsigned TimeW = 15;

  typedef enum logic [1:0] {
    REQ_RISE = 2'd0,
    REQ_FALL = 2'd1,
    REQ_TICK = 2'd2,
    REQ_SCAN = 2'd3
  } req_e;

  // Open windows on the measured high time (both bounds exclusive)
  localparam logic [TimeW-1:0] LeaderLo = 15'd4200;
  localparam logic [TimeW-1:0] LeaderHi = 15'd4700;
  localparam logic [TimeW-1:0] ZeroLo   = 15'd300;
  localparam logic [TimeW-1:0] ZeroHi   = 15'd800;
  localparam logic [TimeW-1:0] OneLo    = 15'd1400;
  localparam logic [TimeW-1:0] OneHi    = 15'd1800;
  localparam logic [TimeW-1:0] RepLo    = 15'd2000;
  localparam logic [TimeW-1:0] RepHi    = 15'd3200;

  // Last timeout count before the decoder gives up on a frame
  localparam logic [3:0] TimeoutLimit = 4'd11;
  localparam logic [7:0] RepeatMax    = 8'd255;

  typedef struct packed {
    logic       leader_seen;
    logic       ready_flag;
    logic       rise_seen;
    logic [3:0] timeout_count;
    logic [7:0] repeats;
  } dec_status_t;

endpackage

[hw/rtl/nec_ir_frame_decoder.sv]
// NEC infrared remote frame decoder, top level.
// Depends on nec_ir_pkg (request kinds, timing windows, status record).
//
// Takes one timing event per request and returns exactly one result per
// request. An event is a rising edge, a falling edge with the measured high
// time, a 20 ms timeout tick, or a scan. The decoder spots the leader, shifts
// the 32 frame bits in MSB first, counts repeat codes (saturating at 255) and
// on a scan checks address against its complement and against the configured
// device address, and command against its complement, returning the command
// byte or 0. A scan of a ready frame that yields 0 clears the whole decoder,
// frame word included. Rate: one request per clock while results are taken;
// a request passes the input register, then the result register, with the
// full state update done in range compares and a one-bit shift between them.
// The user must write the device address only while no request is in flight;
// the block does not enforce it. Reset clears valid flags, state and address.
module nec_ir_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: expected device address byte
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [14:0] high_time, [15] zero pad
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [7:0] key_code, [15:8] repeat_count,
                                        // [16] frame_ready, [23:17] zero pad
);
  import nec_ir_pkg::*;

  // Input register
  logic             in_valid_q;
  req_e             in_type_q;
  logic [TimeW-1:0] in_time_q;

  // Decoder state
  dec_status_t st_q, st_d;
  logic [31:0] word_q, word_d;
  logic [7:0]  dev_addr_q;

  // Result register
  logic       out_valid_q;
  logic [7:0] out_key_q, out_key_d;
  logic [7:0] out_rep_q;
  logic       out_rdy_q;

  logic advance;   // request in the input register moves to the result stage
  logic in_take;

  // The result stage frees up when empty or when its result is taken
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_type_q <= req_e'(s_axis_tuser_i);
      in_time_q <= s_axis_tdata_i[TimeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // Window decode on the held high time
  logic win_leader, win_zero, win_one, win_rep;
  assign win_leader = (in_time_q > LeaderLo) && (in_time_q < LeaderHi);
  assign win_zero   = (in_time_q > ZeroLo)   && (in_time_q < ZeroHi);
  assign win_one    = (in_time_q > OneLo)    && (in_time_q < OneHi);
  assign win_rep    = (in_time_q > RepLo)    && (in_time_q < RepHi);

  // Frame check for a scan
  logic       frame_ok;
  logic [7:0] addr_b, naddr_b, cmd_b, ncmd_b;
  assign addr_b   = word_q[31:24];
  assign naddr_b  = word_q[23:16];
  assign cmd_b    = word_q[15:8];
  assign ncmd_b   = word_q[7:0];
  assign frame_ok = (addr_b == ~naddr_b) && (addr_b == dev_addr_q) &&
                    (cmd_b == ~ncmd_b);

  // Next state and key for the request in the input register
  always_comb begin
    st_d      = st_q;
    word_d    = word_q;
    out_key_d = '0;
    case (in_type_q)
      REQ_RISE: begin
        st_d.rise_seen = 1'b1;
      end
      REQ_FALL: begin
        if (st_q.rise_seen) begin
          if (win_leader) begin
            st_d             = '0;
            st_d.leader_seen = 1'b1;
          end else if (st_q.leader_seen) begin
            if (win_zero) begin
              word_d = {word_q[30:0], 1'b0};
            end else if (win_one) begin
              word_d = {word_q[30:0], 1'b1};
            end else if (win_rep) begin
              st_d.timeout_count = '0;
              if (st_q.repeats != RepeatMax) begin
                st_d.repeats = st_q.repeats + 8'd1;
              end
            end
          end
        end
        st_d.rise_seen = 1'b0;
      end
      REQ_TICK: begin
        if (st_q.leader_seen) begin
          st_d.ready_flag = 1'b1;
          st_d.rise_seen  = 1'b0;
          if (st_q.timeout_count >= TimeoutLimit) begin
            // Give up on the frame; the frame word survives
            st_d = '0;
          end else begin
            st_d.timeout_count = st_q.timeout_count + 4'd1;
          end
        end
      end
      REQ_SCAN: begin
        if (st_q.ready_flag) begin
          out_key_d = frame_ok ? cmd_b : 8'd0;
          // A zero key (bad frame or zero command) drops everything
          if (out_key_d == 8'd0 || !st_q.leader_seen) begin
            st_d      = '0;
            word_d    = '0;
            out_key_d = '0;
          end
        end
      end
      default: begin
        st_d = st_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        st_q   <= st_d;
        word_q <= word_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_key_q <= out_key_d;
      out_rep_q <= st_d.repeats;
      out_rdy_q <= st_d.ready_flag;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_rdy_q, out_rep_q, out_key_q};

  // Timeout count wraps to zero before passing the limit
  a_timeout_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.timeout_count <= TimeoutLimit)
    else $error("timeout count beyond limit");

  // A frame can only be ready while a leader is held
  a_ready_needs_leader: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.ready_flag |-> st_q.leader_seen)
    else $error("ready flag without leader");

  // A nonzero key leaves the frame marked ready
  a_key_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_key_q != 8'd0) |-> out_rdy_q)
    else $error("key delivered without ready frame");

  // An accepted request is held in the input register next cycle
  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted request lost");

  // A result slot that is stalled keeps the state frozen
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> ($stable(st_q) && $stable(word_q)))
    else $error("state moved while result stalled");

endmodule

[test/nec_ir_frame_decoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for nec_ir_frame_decoder: drives timing events,
// predicts each result in a scoreboard class. Depends on nec_ir_pkg and the RTL.
module nec_ir_frame_decoder_tb;
  import nec_ir_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;  // cycles without any handshake
  localparam int unsigned HoldOffCycles = 300;   // long receiver stall
  localparam int unsigned PhaseItems    = 60;

  typedef struct packed {
    logic       frame_ready;
    logic [7:0] repeat_count;
    logic [7:0] key_code;
  } key_result_t;

  // Decoder state copy plus the queue of results still owed by the block.
  class key_scoreboard;
    bit [7:0]    dev_addr;
    bit          leader_seen;
    bit          ready_flag;
    bit          rise_seen;
    bit [3:0]    timeout_count;
    bit [7:0]    repeats;
    bit [31:0]   shift_word;
    key_result_t expected_q[$];
    int          mismatches;

    function new();
      dev_addr   = '0;
      shift_word = '0;
      mismatches = 0;
      clear_status();
    endfunction

    function void clear_status();
      leader_seen   = 1'b0;
      ready_flag    = 1'b0;
      rise_seen     = 1'b0;
      timeout_count = '0;
      repeats       = '0;
    endfunction

    function key_result_t decode_event(req_e kind, bit [14:0] t);
      key_result_t r;
      bit [7:0] a, na, c, nc;
      r.key_code = '0;
      case (kind)
        REQ_RISE: rise_seen = 1'b1;
        REQ_FALL: begin
          if (rise_seen) begin
            if (t > LeaderLo && t < LeaderHi) begin
              clear_status();
              leader_seen = 1'b1;
            end else if (leader_seen) begin
              if (t > ZeroLo && t < ZeroHi) begin
                shift_word = shift_word << 1;
              end else if (t > OneLo && t < OneHi) begin
                shift_word = (shift_word << 1) | 32'd1;
              end else if (t > RepLo && t < RepHi) begin
                timeout_count = '0;
                if (repeats < RepeatMax) repeats++;
              end
            end
          end
          rise_seen = 1'b0;
        end
        REQ_TICK: begin
          if (leader_seen) begin
            ready_flag = 1'b1;
            rise_seen  = 1'b0;
            if (timeout_count >= TimeoutLimit) clear_status();
            else timeout_count++;
          end
        end
        default: begin
          if (ready_flag) begin
            {a, na, c, nc} = shift_word;
            if (a == ~na && a == dev_addr && c == ~nc) r.key_code = c;
            // Zero key means no valid frame: drop everything, frame word too
            if (r.key_code == 8'd0 || !leader_seen) begin
              clear_status();
              shift_word = '0;
            end
          end
        end
      endcase
      r.repeat_count = repeats;
      r.frame_ready  = ready_flag;
      return r;
    endfunction

    function void note_request(req_e kind, bit [14:0] t);
      expected_q.push_back(decode_event(kind, t));
    endfunction

    function void check_result(logic [23:0] data);
      key_result_t got, want;
      got = data[16:0];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: unexpected result %h", data);
        return;
      end
      want = expected_q.pop_front();
      if (got.key_code !== want.key_code || got.repeat_count !== want.repeat_count ||
          got.frame_ready !== want.frame_ready) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: key %h/%h repeats %0d/%0d ready %b/%b (expected/actual)",
                   want.key_code, got.key_code, want.repeat_count, got.repeat_count,
                   want.frame_ready, got.frame_ready);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic [15:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tready  = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;

  key_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_wanted  = 0;
  int stall_done    = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  always #5 clk_i = ~clk_i;

  nec_ir_frame_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_wanted != stall_done) begin
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        stall_done++;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check every result the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o);
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
      $display("FAIL nec_ir_frame_decoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, idling first at random; hold it until accepted.
  task automatic send_req(input req_e kind, input logic [14:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, t};
    s_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(kind, t);
    items_sent++;
  endtask

  function automatic logic [14:0] any_time();
    return 15'($urandom_range(0, 19999));
  endfunction

  // Rising edge (time ignored, so random) followed by a falling edge with t.
  task automatic send_pulse(input logic [14:0] t);
    send_req(REQ_RISE, any_time());
    send_req(REQ_FALL, t);
  endtask

  task automatic send_noise();
    logic [1:0] k;
    k = 2'($urandom_range(0, 3));
    send_req(req_e'(k), any_time());
  endtask

  function automatic logic [14:0] zero_time();
    return 15'($urandom_range(ZeroLo + 1, ZeroHi - 1));
  endfunction

  function automatic logic [14:0] one_time();
    return 15'($urandom_range(OneLo + 1, OneHi - 1));
  endfunction

  function automatic logic [14:0] repeat_time();
    return 15'($urandom_range(RepLo + 1, RepHi - 1));
  endfunction

  // Leader, nbits frame bits MSB first, repeat codes, ticks and scans.
  task automatic send_frame(input logic [31:0] word, input int nbits, input int reps,
                            input int ticks, input int scans, input bit noisy);
    send_pulse(15'($urandom_range(LeaderLo + 1, LeaderHi - 1)));
    for (int i = nbits - 1; i >= 0; i--) begin
      if (noisy && $urandom_range(0, 31) == 0) send_noise();
      send_pulse(word[i] ? one_time() : zero_time());
    end
    repeat (reps) send_pulse(repeat_time());
    repeat (ticks) send_req(REQ_TICK, any_time());
    repeat (scans) send_req(REQ_SCAN, any_time());
  endtask

  // Mostly well-formed frames aimed at the current device address.
  function automatic logic [31:0] frame_word();
    logic [7:0] a, na, c, nc;
    a  = ($urandom_range(0, 9) < 7) ? sb.dev_addr : 8'($urandom);
    na = ($urandom_range(0, 9) < 8) ? ~a : 8'($urandom);
    c  = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom);
    nc = ($urandom_range(0, 9) < 8) ? ~c : 8'($urandom);
    return {a, na, c, nc};
  endfunction

  task automatic run_sequence();
    logic [14:0] edges[16];
    int ticks;
    edges = '{15'd300, 15'd301, 15'd799, 15'd800, 15'd1400, 15'd1401, 15'd1799, 15'd1800,
              15'd2000, 15'd2001, 15'd3199, 15'd3200, 15'd4200, 15'd4201, 15'd4699, 15'd4700};
    ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 13) : $urandom_range(1, 3);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        send_frame(frame_word(), 32, $urandom_range(0, 3), ticks, $urandom_range(1, 2),
                   $urandom_range(0, 3) == 0);
      6: send_frame(frame_word(), $urandom_range(0, 31), $urandom_range(0, 2), ticks, 1, 0);
      7, 8: repeat ($urandom_range(1, 8)) send_noise();
      default: begin
        // Window boundaries after a leader
        send_pulse(15'($urandom_range(LeaderLo + 1, LeaderHi - 1)));
        repeat (4) send_pulse(edges[$urandom_range(0, 15)]);
        if ($urandom_range(0, 1) == 0) send_req(REQ_TICK, any_time());
        send_req(REQ_SCAN, any_time());
      end
    endcase
  endtask

  // Drain the block, then write the device address while nothing is in flight.
  task automatic write_dev_addr(input logic [7:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    sb.dev_addr = value;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [7:0] id,
                           input bit with_directed);
    int goal;
    write_dev_addr(id);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = items_sent + PhaseItems;
    if (with_directed) begin
      // Events that must be ignored with no frame around
      send_req(REQ_SCAN, 15'd19999);
      send_req(REQ_FALL, 15'd4500);
      send_req(REQ_TICK, 15'd0);
      // Leader bounds are exclusive
      send_pulse(15'd4200);
      send_pulse(15'd4700);
      send_pulse(15'd4201);
      // Out-of-range times, a repeat code, then a scan of an all-zero word
      send_pulse(15'd0);
      send_pulse(15'd19999);
      send_pulse(15'd2500);
      send_req(REQ_TICK, 15'd32);
      send_req(REQ_SCAN, 15'd16384);
      // Timeout: the twelfth tick clears the decoder
      send_frame(32'h0, 0, 0, 12, 1, 0);
      // Valid frame with a zero command byte reads as invalid
      send_frame({id, ~id, 8'h00, 8'hFF}, 32, 0, 1, 1, 0);
    end
    stall_wanted++;
    while (items_sent < goal) run_sequence();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(28, 63, 8'h00, 1'b1);
    run_phase(63, 28, 8'hFF, 1'b0);
    run_phase(0, 0, 8'($urandom), 1'b0);
    // Repeat counter saturation, with a valid frame so the scan keeps state
    send_frame({sb.dev_addr, ~sb.dev_addr, 8'h5A, 8'hA5}, 32, 258, 1, 2, 0);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) $display("PASS nec_ir_frame_decoder");
    else $display("FAIL nec_ir_frame_decoder");
    $finish;
  end

endmodule
